@@ rtl/vcm_pkg.sv @@
// Shared constants, codes and state encoding for the voltage channel monitor.
// No dependencies; imported by voltage_channel_monitor.
`default_nettype none

package vcm_pkg;

  // Field widths
  localparam int ADC_W  = 12;  // ADC reading and offset, mV
  localparam int Q_W    = 16;  // Q8.8 ratio and inverse gain
  localparam int Q_FRAC = 8;   // fraction bits of a Q8.8 value
  localparam int V_W    = 20;  // converted voltage, signed
  localparam int EXT_W  = 21;  // min/max seen, signed
  localparam int RMS_W  = 19;
  localparam int CNT_W  = 32;
  localparam int CFG_W  = 20;  // widest register
  localparam int IDX_W  = 3;

  // History window; must be a power of two (the mean is a shift)
  localparam int HISTORY_DEPTH = 16;
  localparam int SLOT_W        = $clog2(HISTORY_DEPTH);

  // Conversion datapath
  localparam int PROD_W = ADC_W + 2 * Q_W;   // |d| * ratio * gain
  localparam int MAG_W  = PROD_W - 2 * Q_FRAC; // magnitude after the Q shift
  localparam int CV_W   = MAG_W + 1;         // signed converted value
  localparam int MB_W   = (Q_W > V_W) ? Q_W : V_W; // serial multiplier operand

  // Sum of squares and root
  localparam int SUM_W    = 2 * V_W - 1 + SLOT_W;
  localparam int RAD_W    = SUM_W - SLOT_W;
  localparam int ROOT_W   = (RAD_W + 1) / 2;
  localparam int RAD_PAD  = 2 * ROOT_W;
  localparam int REM_W    = ROOT_W + 3;
  localparam int STEP_W   = $clog2(ROOT_W);
  localparam int RMS_MAX  = 2 ** RMS_W - 1;

  // Threshold products (20*v, 19*hi, 21*lo)
  localparam int TH_W = V_W + 6;

  // Rounding constants, half away from zero on the magnitude
  localparam logic [PROD_W-1:0] RND_DIV = PROD_W'(1) << (2 * Q_FRAC - 1);
  localparam logic [PROD_W-1:0] RND_ISO = PROD_W'(1) << (Q_FRAC - 1);

  // Register reset values
  localparam logic [Q_W-1:0]          RATIO_RESET   = Q_W'(7680);
  localparam logic [Q_W-1:0]          GAIN_RESET    = Q_W'(256);
  localparam logic signed [V_W-1:0]   MAX_LIM_RESET = V_W'(100000);
  localparam logic signed [EXT_W-1:0] LOWEST_RESET  = EXT_W'(1000000);
  localparam logic signed [EXT_W-1:0] HIGHEST_RESET = -EXT_W'(1000000);

  typedef enum logic [1:0] {
    SENSOR_DIVIDER      = 2'd0,
    SENSOR_ISOLATION    = 2'd1,
    SENSOR_DIFFERENTIAL = 2'd2,
    SENSOR_DIRECT       = 2'd3
  } sensor_t;

  typedef enum logic [IDX_W-1:0] {
    REG_SENSOR_TYPE = 3'd0,
    REG_OFFSET      = 3'd1,
    REG_RATIO       = 3'd2,
    REG_INV_GAIN    = 3'd3,
    REG_MIN_LIMIT   = 3'd4,
    REG_MAX_LIMIT   = 3'd5
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_RATIO,
    ST_MUL_GAIN,
    ST_MUL_ISO,
    ST_CHECK,
    ST_SQ_OLD,
    ST_SQ_NEW,
    ST_SQRT,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

@@ rtl/voltage_channel_monitor.sv @@
// Voltage channel monitor: conversion, limit checking, windowed RMS and statistics.
// Depends on vcm_pkg (widths, codes, state encoding).
`default_nettype none

// One sensor channel. Each item is an ADC reading in mV (or an ADC error mark)
// and gives exactly one result. The reading is converted by sensor type:
// divider and differential apply (adc - offset) * ratio * inverse gain in Q8.8,
// isolation applies (adc - offset) * inverse gain, direct passes the reading,
// the magnitude rounded half away from zero. An ADC error or a voltage outside
// [min_limit_mv, max_limit_mv] raises fault and bumps the fault count; the
// reported voltage is then saturated to 20 bits (0 on ADC error) and nothing
// else moves. A good reading clears fault, sets over/under against 95 % and
// 105 % of the limits, enters a 16-deep history and its sum of squares, and
// updates peak, min, max and the good count; rms_mv is then recomputed as
// floor(sqrt(sum / 16)), saturated to 19 bits. Counters stick at all ones.
// Timing: one item at a time. The conversion and square multiplies go through
// one shift-and-add unit that retires one bit of its multiplier per cycle and
// stops when that operand runs out; the root is found two radicand bits per
// cycle. A faulted item passes acceptance, any conversion and the check before
// its result; a good one also forms the squares of the leaving and the new
// sample and the root before the hand-over.
// in_ready is high only while idle; the result sits in an output register, so
// a new item is taken while the previous result still waits for out_ready.
// Configuration writes take effect at once and are meant for idle periods.
module voltage_channel_monitor import vcm_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // configuration
  input  wire logic                     cfg_we,
  input  wire logic [IDX_W-1:0]         cfg_index,
  input  wire logic [CFG_W-1:0]         cfg_data,
  // input items
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [ADC_W-1:0]         adc_mv,
  input  wire logic                     adc_error,
  // result items
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [V_W-1:0]         voltage_mv,
  output logic [RMS_W-1:0]              rms_mv,
  output logic signed [V_W-1:0]         peak_mv,
  output logic signed [EXT_W-1:0]       min_seen_mv,
  output logic signed [EXT_W-1:0]       max_seen_mv,
  output logic                          over_flag,
  output logic                          under_flag,
  output logic                          fault_flag,
  output logic                          valid_flag,
  output logic [CNT_W-1:0]              fault_total,
  output logic [CNT_W-1:0]              reading_total
);

  function automatic logic [EXT_W-1:0] abs_ext(input logic signed [V_W-1:0] x);
    logic signed [EXT_W-1:0] xe;
    xe = EXT_W'(x);
    return xe[EXT_W-1] ? $unsigned(-xe) : $unsigned(xe);
  endfunction

  // ---------------------------------------------------------------- registers
  state_t state, state_next;

  // configuration
  sensor_t                 sensor_type;
  logic [ADC_W-1:0]        offset_mv;
  logic [Q_W-1:0]          divider_ratio_q8;
  logic [Q_W-1:0]          inverse_gain_q8;
  logic signed [V_W-1:0]   min_limit_mv;
  logic signed [V_W-1:0]   max_limit_mv;

  // per-item working registers
  logic                    err_l;
  logic                    neg;
  logic [PROD_W-1:0]       mul_a;
  logic [MB_W-1:0]         mul_b;
  logic [PROD_W-1:0]       acc;
  logic signed [CV_W-1:0]  conv_v;
  logic [MB_W-1:0]         new_mag;
  logic signed [V_W-1:0]   res_v;
  logic [RAD_PAD-1:0]      rad;
  logic [REM_W-1:0]        rem;
  logic [ROOT_W-1:0]       root;
  logic [STEP_W-1:0]       sq_step;

  // channel state
  logic signed [V_W-1:0]   hist [HISTORY_DEPTH];
  logic [SLOT_W-1:0]       write_slot;
  logic [SUM_W-1:0]        square_sum;
  logic signed [V_W-1:0]   peak_value;
  logic signed [EXT_W-1:0] lowest_seen;
  logic signed [EXT_W-1:0] highest_seen;
  logic [CNT_W-1:0]        fail_count;
  logic [CNT_W-1:0]        good_count;
  logic                    over_bit, under_bit, fault_bit, valid_bit;
  logic [RMS_W-1:0]        rms;

  // ---------------------------------------------------------- datapath terms
  logic signed [ADC_W:0]   diff;
  logic [ADC_W:0]          diff_abs;
  logic [PROD_W-1:0]       mul_sum;
  logic                    mul_done;
  logic [MAG_W-1:0]        mag_sel;
  logic signed [CV_W-1:0]  mag_s;
  logic signed [CV_W-1:0]  conv_next;
  logic signed [CV_W-1:0]  lo_x, hi_x;
  logic                    out_of_range;
  logic                    sat_hit;
  logic signed [V_W-1:0]   v20, v_sat;
  logic signed [TH_W-1:0]  v_t, hi_t, lo_t, v_x20, hi_x19, lo_x21;
  logic                    over_now, under_now;
  logic [EXT_W-1:0]        v_mag, pk_mag, old_mag;
  logic signed [EXT_W-1:0] v21;
  logic [SUM_W-1:0]        sum_next;
  logic [REM_W-1:0]        rem_sh, trial;
  logic                    root_ge;
  logic [ROOT_W-1:0]       root_next;
  logic                    out_load;

  assign diff     = $signed({1'b0, adc_mv}) - $signed({1'b0, offset_mv});
  assign diff_abs = diff[ADC_W] ? $unsigned(-diff) : $unsigned(diff);

  // shift-and-add: one multiplier bit per cycle
  assign mul_sum  = acc + (mul_b[0] ? mul_a : '0);
  assign mul_done = (mul_b == '0);

  assign mag_sel   = (state == ST_MUL_GAIN) ? acc[2*Q_FRAC +: MAG_W] : acc[Q_FRAC +: MAG_W];
  assign mag_s     = $signed({1'b0, mag_sel});
  assign conv_next = neg ? -mag_s : mag_s;

  // limit check on the full-width converted value
  assign lo_x         = CV_W'(min_limit_mv);
  assign hi_x         = CV_W'(max_limit_mv);
  assign out_of_range = err_l || (conv_v < lo_x) || (conv_v > hi_x);
  assign sat_hit      = (conv_v[CV_W-1:V_W-1] != '0) && (conv_v[CV_W-1:V_W-1] != '1);
  assign v20          = conv_v[V_W-1:0];
  assign v_sat        = sat_hit ? {conv_v[CV_W-1], {(V_W-1){~conv_v[CV_W-1]}}} : v20;

  // exact 95 % / 105 % tests: 20*v > 19*hi, 20*v < 21*lo
  assign v_t       = TH_W'(v20);
  assign hi_t      = TH_W'(max_limit_mv);
  assign lo_t      = TH_W'(min_limit_mv);
  assign v_x20     = (v_t <<< 4) + (v_t <<< 2);
  assign hi_x19    = (hi_t <<< 4) + (hi_t <<< 1) + hi_t;
  assign lo_x21    = (lo_t <<< 4) + (lo_t <<< 2) + lo_t;
  assign over_now  = v_x20 > hi_x19;
  assign under_now = v_x20 < lo_x21;

  assign v_mag   = abs_ext(v20);
  assign pk_mag  = abs_ext(peak_value);
  assign old_mag = abs_ext(hist[write_slot]);
  assign v21     = EXT_W'(v20);

  assign sum_next = square_sum + acc[SUM_W-1:0];

  // restoring square root, two radicand bits per step
  assign rem_sh    = {rem[REM_W-3:0], rad[RAD_PAD-1 -: 2]};
  assign trial     = {1'b0, root, 2'b01};
  assign root_ge   = rem_sh >= trial;
  assign root_next = {root[ROOT_W-2:0], root_ge};

  // ------------------------------------------------------------ control FSM
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (adc_error) begin
            state_next = ST_CHECK;
          end else begin
            unique case (sensor_type)
              SENSOR_DIVIDER, SENSOR_DIFFERENTIAL: state_next = ST_MUL_RATIO;
              SENSOR_ISOLATION:                    state_next = ST_MUL_ISO;
              SENSOR_DIRECT:                       state_next = ST_CHECK;
            endcase
          end
        end
      end
      ST_MUL_RATIO: if (mul_done) state_next = ST_MUL_GAIN;
      ST_MUL_GAIN:  if (mul_done) state_next = ST_CHECK;
      ST_MUL_ISO:   if (mul_done) state_next = ST_CHECK;
      ST_CHECK:     state_next = out_of_range ? ST_DONE : ST_SQ_OLD;
      ST_SQ_OLD:    if (mul_done) state_next = ST_SQ_NEW;
      ST_SQ_NEW:    if (mul_done) state_next = ST_SQRT;
      ST_SQRT:      if (sq_step == STEP_W'(ROOT_W - 1)) state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_type      <= SENSOR_DIVIDER;
      offset_mv        <= '0;
      divider_ratio_q8 <= RATIO_RESET;
      inverse_gain_q8  <= GAIN_RESET;
      min_limit_mv     <= '0;
      max_limit_mv     <= MAX_LIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SENSOR_TYPE: sensor_type      <= sensor_t'(cfg_data[1:0]);
        REG_OFFSET:      offset_mv        <= cfg_data[ADC_W-1:0];
        REG_RATIO:       divider_ratio_q8 <= cfg_data[Q_W-1:0];
        REG_INV_GAIN:    inverse_gain_q8  <= cfg_data[Q_W-1:0];
        REG_MIN_LIMIT:   min_limit_mv     <= $signed(cfg_data[V_W-1:0]);
        REG_MAX_LIMIT:   max_limit_mv     <= $signed(cfg_data[V_W-1:0]);
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // --------------------------------------------------- per-item working data
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          err_l  <= adc_error;
          neg    <= diff[ADC_W];
          acc    <= '0;
          mul_b  <= MB_W'(diff_abs[ADC_W-1:0]);
          conv_v <= '0;
          if (!adc_error) begin
            unique case (sensor_type)
              SENSOR_DIVIDER, SENSOR_DIFFERENTIAL: mul_a <= PROD_W'(divider_ratio_q8);
              SENSOR_ISOLATION: begin
                mul_a <= PROD_W'(inverse_gain_q8);
                acc   <= RND_ISO;
              end
              SENSOR_DIRECT: conv_v <= CV_W'($signed({1'b0, adc_mv}));
            endcase
          end
        end
      end
      ST_MUL_RATIO: begin
        if (mul_done) begin
          // |d| * ratio becomes the multiplicand for the gain pass
          mul_a <= acc;
          mul_b <= MB_W'(inverse_gain_q8);
          acc   <= RND_DIV;
        end else begin
          acc   <= mul_sum;
          mul_a <= mul_a << 1;
          mul_b <= mul_b >> 1;
        end
      end
      ST_MUL_GAIN, ST_MUL_ISO: begin
        if (mul_done) begin
          conv_v <= conv_next;
        end else begin
          acc   <= mul_sum;
          mul_a <= mul_a << 1;
          mul_b <= mul_b >> 1;
        end
      end
      ST_CHECK: begin
        res_v <= out_of_range ? v_sat : v20;
        // square of the sample leaving the window first
        mul_a   <= PROD_W'(old_mag);
        mul_b   <= old_mag[MB_W-1:0];
        acc     <= '0;
        new_mag <= v_mag[MB_W-1:0];
      end
      ST_SQ_OLD: begin
        if (mul_done) begin
          mul_a <= PROD_W'(new_mag);
          mul_b <= new_mag;
          acc   <= '0;
        end else begin
          acc   <= mul_sum;
          mul_a <= mul_a << 1;
          mul_b <= mul_b >> 1;
        end
      end
      ST_SQ_NEW: begin
        if (mul_done) begin
          rad     <= RAD_PAD'(sum_next[SUM_W-1:SLOT_W]);
          rem     <= '0;
          root    <= '0;
          sq_step <= '0;
        end else begin
          acc   <= mul_sum;
          mul_a <= mul_a << 1;
          mul_b <= mul_b >> 1;
        end
      end
      ST_SQRT: begin
        rem     <= root_ge ? rem_sh - trial : rem_sh;
        root    <= root_next;
        rad     <= rad << 2;
        sq_step <= sq_step + STEP_W'(1);
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // ------------------------------------------------------------ channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist[i] <= '0;
      end
      write_slot   <= '0;
      square_sum   <= '0;
      peak_value   <= '0;
      lowest_seen  <= LOWEST_RESET;
      highest_seen <= HIGHEST_RESET;
      fail_count   <= '0;
      good_count   <= '0;
      over_bit     <= 1'b0;
      under_bit    <= 1'b0;
      fault_bit    <= 1'b0;
      valid_bit    <= 1'b0;
      rms          <= '0;
    end else begin
      if (state == ST_CHECK) begin
        if (out_of_range) begin
          fault_bit <= 1'b1;
          if (fail_count != '1) fail_count <= fail_count + CNT_W'(1);
        end else begin
          fault_bit <= 1'b0;
          valid_bit <= 1'b1;
          over_bit  <= over_now;
          under_bit <= under_now;
          hist[write_slot] <= v20;
          write_slot <= write_slot + SLOT_W'(1);
          if (v_mag > pk_mag)      peak_value   <= v20;
          if (v21 < lowest_seen)   lowest_seen  <= v21;
          if (v21 > highest_seen)  highest_seen <= v21;
          if (good_count != '1) good_count <= good_count + CNT_W'(1);
        end
      end
      // sum of squares: drop the old sample, then add the new one
      if (state == ST_SQ_OLD && mul_done) square_sum <= square_sum - acc[SUM_W-1:0];
      if (state == ST_SQ_NEW && mul_done) square_sum <= sum_next;
      if (state == ST_SQRT && sq_step == STEP_W'(ROOT_W - 1)) begin
        rms <= (root_next > ROOT_W'(RMS_MAX)) ? '1 : root_next[RMS_W-1:0];
      end
    end
  end

  // ------------------------------------------------------------ result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      voltage_mv    <= res_v;
      rms_mv        <= rms;
      peak_mv       <= peak_value;
      min_seen_mv   <= lowest_seen;
      max_seen_mv   <= highest_seen;
      over_flag     <= over_bit;
      under_flag    <= under_bit;
      fault_flag    <= fault_bit;
      valid_flag    <= valid_bit;
      fault_total   <= fail_count;
      reading_total <= good_count;
    end
  end

endmodule

`default_nettype wire
